@@ rtl/pfc_pkg.sv @@
// Shared types, codes and helpers for the primary/standby failover controller.
package pfc_pkg;

   localparam int unsigned LOG_DEPTH  = 256;
   localparam int unsigned LOG_FILL_W = $clog2(LOG_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_SET_ROLE   = 3'd0,
      OP_START_SYNC = 3'd1,
      OP_FAILOVER   = 3'd2,
      OP_MANUAL_SW  = 3'd3,
      OP_UPD_HEALTH = 3'd4,
      OP_STATUS     = 3'd5
   } op_type;

   localparam logic [2:0] ROLE_OFFLINE  = 3'd0;
   localparam logic [2:0] ROLE_PRIMARY  = 3'd1;
   localparam logic [2:0] ROLE_STANDBY  = 3'd2;
   localparam logic [2:0] ROLE_SYNCING  = 3'd3;
   localparam logic [2:0] ROLE_MAINT    = 3'd4;
   localparam logic [2:0] ROLE_ISOLATED = 3'd5;

   localparam logic [2:0] SYNC_IDLE     = 3'd0;
   localparam logic [2:0] SYNC_COPYING  = 3'd1;
   localparam logic [2:0] SYNC_TRACKING = 3'd3;
   localparam logic [2:0] SYNC_SYNCED   = 3'd4;
   localparam logic [2:0] SYNC_MISMATCH = 3'd5;

   localparam logic [1:0] KIND_MANUAL = 2'd0;

   // health flag bit positions
   localparam int unsigned H_HW  = 0;
   localparam int unsigned H_SW  = 1;
   localparam int unsigned H_MEM = 2;
   localparam int unsigned H_DB  = 3;

   localparam logic [10:0] MS_BUMPLESS = 11'd150;
   localparam logic [10:0] MS_TRACKING = 11'd500;
   localparam logic [10:0] MS_COLD     = 11'd2000;

   localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0] operation;
      logic       member_slot;
      logic [2:0] target_role;
      logic [1:0] failover_kind;
      logic       hardware_ok;
      logic       software_ok;
      logic       memory_ok;
      logic       database_ok;
      logic       force_mismatch;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  primary_role_out;
      logic [2:0]  standby_role_out;
      logic [2:0]  primary_sync_out;
      logic [2:0]  standby_sync_out;
      logic        pair_ok;
      logic        bumpless_ok;
      logic [10:0] switchover_ms;
      logic [15:0] failover_total_out;
      logic [8:0]  log_fill_out;
      logic [1:0]  latest_kind;
      logic        latest_success;
   } rsp_type;

   function automatic logic sync_ok(input logic [2:0] s);
      return (s == SYNC_SYNCED) || (s == SYNC_TRACKING);
   endfunction

   function automatic logic sync_health(input logic [2:0] s0, input logic [2:0] s1,
                                        input logic [3:0] h0, input logic [3:0] h1);
      return sync_ok(s0) && sync_ok(s1) && h0[H_MEM] && h1[H_MEM] && h0[H_DB] && h1[H_DB];
   endfunction

endpackage

@@ rtl/pfc_engine.sv @@
// Pair state registers and the single-pass update for one transaction.
module pfc_engine import pfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    take,
   input  req_type req,
   output rsp_type result
);

   logic [2:0]            role_ff [2];
   logic [2:0]            role_in [2];
   logic [2:0]            sync_ff [2];
   logic [2:0]            sync_in [2];
   logic [3:0]            health_ff [2];
   logic [3:0]            health_in [2];
   logic [15:0]           total_ff, total_in;
   logic [LOG_FILL_W-1:0] fill_ff, fill_in;
   logic [2:0]            latest_ff, latest_in;

   logic       acc;
   logic       fo_req;
   logic [1:0] fo_kind;
   logic       sh_cur;
   logic       pair_cur;
   logic       role_ok;
   logic [2:0] role_now;
   logic       bump;

   always_comb begin
      role_in   = role_ff;
      sync_in   = sync_ff;
      health_in = health_ff;
      total_in  = total_ff;
      fill_in   = fill_ff;
      latest_in = latest_ff;
      acc       = 1'b0;
      fo_req    = 1'b0;
      fo_kind   = req.failover_kind;
      sh_cur    = sync_health(sync_ff[0], sync_ff[1], health_ff[0], health_ff[1]);
      pair_cur  = sh_cur && health_ff[0][H_HW] && health_ff[1][H_HW]
                  && health_ff[0][H_SW] && health_ff[1][H_SW];
      role_now  = role_ff[req.member_slot];
      role_ok   = (req.target_role <= ROLE_ISOLATED)
                  && !(role_now == ROLE_OFFLINE && req.target_role == ROLE_PRIMARY)
                  && !(role_now == ROLE_ISOLATED && req.target_role != ROLE_OFFLINE
                       && req.target_role != ROLE_MAINT);

      unique case (req.operation)
         OP_SET_ROLE: begin
            if (role_ok) begin
               acc = 1'b1;
               role_in[req.member_slot] = req.target_role;
               priority if (req.target_role == ROLE_PRIMARY) begin
                  sync_in[req.member_slot] = SYNC_SYNCED;
               end else if (req.target_role == ROLE_STANDBY) begin
                  sync_in[req.member_slot] = SYNC_TRACKING;
               end else if (req.target_role == ROLE_SYNCING) begin
                  sync_in[req.member_slot] = SYNC_COPYING;
               end else begin
                  sync_in[req.member_slot] = SYNC_IDLE;
               end
            end
         end
         OP_START_SYNC: begin
            if (role_ff[0] != ROLE_OFFLINE && role_ff[1] != ROLE_OFFLINE) begin
               acc        = 1'b1;
               role_in[1] = ROLE_SYNCING;
               sync_in[1] = SYNC_COPYING;
            end
         end
         OP_FAILOVER: begin
            fo_req = 1'b1;
         end
         OP_MANUAL_SW: begin
            fo_req  = pair_cur;
            fo_kind = KIND_MANUAL;
         end
         OP_UPD_HEALTH: begin
            acc = 1'b1;
            health_in[req.member_slot] = {req.database_ok, req.memory_ok,
                                          req.software_ok, req.hardware_ok};
            if (req.force_mismatch) begin
               sync_in[req.member_slot] = SYNC_MISMATCH;
            end
         end
         OP_STATUS: begin
            acc = 1'b1;
         end
         default: begin
            acc = 1'b0;
         end
      endcase

      // swap slots and log the event when the standby can take over
      if (fo_req && role_ff[1] == ROLE_STANDBY && sync_ff[1] != SYNC_MISMATCH) begin
         acc          = 1'b1;
         latest_in    = {sh_cur, fo_kind};
         if (fill_ff < LOG_FILL_W'(LOG_DEPTH)) begin
            fill_in = fill_ff + LOG_FILL_W'(1);
         end
         sync_in[0]   = sync_ff[1];
         sync_in[1]   = sync_ff[0];
         health_in[0] = health_ff[1];
         health_in[1] = health_ff[0];
         role_in[0]   = ROLE_PRIMARY;
         role_in[1]   = ROLE_STANDBY;
         if (total_ff != TOTAL_MAX) begin
            total_in = total_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff[0]   <= ROLE_OFFLINE;
         role_ff[1]   <= ROLE_OFFLINE;
         sync_ff[0]   <= SYNC_IDLE;
         sync_ff[1]   <= SYNC_IDLE;
         health_ff[0] <= '0;
         health_ff[1] <= '0;
         total_ff     <= '0;
         fill_ff      <= '0;
         latest_ff    <= '0;
      end else if (take) begin
         role_ff   <= role_in;
         sync_ff   <= sync_in;
         health_ff <= health_in;
         total_ff  <= total_in;
         fill_ff   <= fill_in;
         latest_ff <= latest_in;
      end
   end

   // report the state after the step
   always_comb begin
      bump = (sync_in[1] == SYNC_SYNCED) && health_in[0][H_HW] && health_in[1][H_HW]
             && health_in[0][H_DB] && health_in[1][H_DB];
      result.accepted         = acc;
      result.primary_role_out = role_in[0];
      result.standby_role_out = role_in[1];
      result.primary_sync_out = sync_in[0];
      result.standby_sync_out = sync_in[1];
      result.pair_ok          = sync_health(sync_in[0], sync_in[1], health_in[0], health_in[1])
                                && health_in[0][H_HW] && health_in[1][H_HW]
                                && health_in[0][H_SW] && health_in[1][H_SW];
      result.bumpless_ok      = bump;
      priority if (bump) begin
         result.switchover_ms = MS_BUMPLESS;
      end else if (sync_in[1] == SYNC_TRACKING) begin
         result.switchover_ms = MS_TRACKING;
      end else begin
         result.switchover_ms = MS_COLD;
      end
      result.failover_total_out = total_in;
      result.log_fill_out       = 9'(fill_in);
      result.latest_kind        = latest_in[1:0];
      result.latest_success     = latest_in[2];
   end

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      total_ff >= $past(total_ff))
      else $error("failover total decreased");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LOG_FILL_W'(LOG_DEPTH))
      else $error("log fill beyond depth");

   a_empty_log_clear: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> latest_ff == '0 && total_ff == '0)
      else $error("log entry without a failover");

   a_failover_roles: assert property (@(posedge clock) disable iff (reset)
      take && total_in != total_ff |=> role_ff[0] == ROLE_PRIMARY
                                       && role_ff[1] == ROLE_STANDBY)
      else $error("roles not set after failover");

endmodule

@@ rtl/redundant_pair_failover_controller_top.sv @@
// Latency: a result appears in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle while each result is taken; the state update and all
// status checks are one combinational pass from the request port into the result register.
// The result register frees itself when taken, so a new request enters while it drains.
// Reset: synchronous, active high; both slots offline and idle, health, counter and log clear.
// Top level of the primary/standby failover controller.
module redundant_pair_failover_controller_top import pfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    take;
   rsp_type result;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   pfc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .req    (req_payload),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !take |=> !rsp_valid)
      else $error("result repeated after it was taken");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !take)
      else $error("request taken over a waiting result");

endmodule
